// ----- hw/rtl/bdq_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package bdq_pkg;

  localparam int unsigned DEPTH_DEF   = 16;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned CMD_W       = 3;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned COUNT_W     = 5;
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 48;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_PEEK_FRONT = 3'd4,
    CMD_PEEK_BACK  = 3'd5
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD      = 2'd0,
    CELL_SHIFT_R   = 2'd1,
    CELL_SHIFT_L   = 2'd2,
    CELL_LOAD_BACK = 2'd3
  } cell_op_e;

  typedef struct packed {
    cell_op_e          op;
    logic [DATA_W-1:0] wdata;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/bdq_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

module bdq_cell
  import bdq_pkg::*;
#(
  parameter int unsigned CNT_W = 5,
  parameter int unsigned INDEX = 0
) (
  input  wire                     clk_i,
  input  wire cell_ctrl_t         ctrl_i,
  input  wire logic [CNT_W-1:0]   count_i,
  input  wire logic [DATA_W-1:0]  left_i,
  input  wire logic [DATA_W-1:0]  right_i,
  output logic      [DATA_W-1:0]  data_o,
  output logic      [DATA_W-1:0]  back_data_o
);

  logic [DATA_W-1:0] data_q, data_d;
  logic              at_tail;
  logic              is_back;

  assign at_tail = (count_i == CNT_W'(INDEX));
  assign is_back = (count_i == CNT_W'(INDEX + 1));

  always_comb begin
    data_d = data_q;
    case (ctrl_i.op)
      CELL_SHIFT_R:   data_d = left_i;
      CELL_SHIFT_L:   data_d = right_i;
      CELL_LOAD_BACK: if (at_tail) data_d = ctrl_i.wdata;
      default:        data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o      = data_q;
  assign back_data_o = is_back ? data_q : '0;

endmodule

`default_nettype wire

// ----- hw/rtl/bounded_deque.sv -----
// bounded_deque: double-ended queue of signed 32-bit words, DEPTH deep.
// Input channel s_axis: one item per command (push/pop/peek at front or
// back) with the word to insert. Output channel m_axis: one result item per
// command with the word read, status (ok, full, empty), the count held after
// the command and empty/full flags.
// Storage is a row of DEPTH cells; the front word always sits in cell 0.
// Push front and pop front shift the whole row by one cell; push
// back loads the cell at the current count; the back word is picked from the
// cell just below the count.
// The result is registered and shown in the cycle after the command is accepted.
// Throughput: one command per cycle while the output is not stalled.
// A result waits in the output register while m_axis_tready is low; a new
// command is taken in the same cycle the waiting result leaves, so a stall
// holds the input side for exactly as long as the output is stalled.
// Reset empties the deque (count zero) and drops any pending result; the
// cell contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module bounded_deque
  import bdq_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          s_axis_tvalid,
  output logic                         s_axis_tready,
  // [2:0] command, [34:3] value_in, [39:35] zero
  input  wire logic [IN_TDATA_W-1:0]   s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  wire                          m_axis_tready,
  // [31:0] value_out, [33:32] status, [38:34] count,
  // [39] is_empty_flag, [40] is_full_flag, [47:41] zero
  output logic      [OUT_TDATA_W-1:0]  m_axis_tdata
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic                     accept;
  logic [CMD_W-1:0]         cmd_raw;
  logic signed [DATA_W-1:0] value_in;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic                     full, empty;
  cell_op_e                 op;
  cell_ctrl_t               cell_ctrl;
  logic signed [DATA_W-1:0] result;
  status_e                  status;

  logic [DATA_W-1:0] cell_data [DEPTH];
  logic [DATA_W-1:0] cell_back [DEPTH];
  logic [DATA_W-1:0] front_word;
  logic [DATA_W-1:0] back_word;

  logic                     out_valid_q;
  logic signed [DATA_W-1:0] out_value_q;
  status_e                  out_status_q;
  logic [COUNT_W-1:0]       out_count_q;
  logic                     out_empty_q, out_full_q;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cmd_raw       = s_axis_tdata[CMD_W-1:0];
  assign value_in      = s_axis_tdata[CMD_W +: DATA_W];
  assign full          = (cnt_q == CNT_W'(DEPTH));
  assign empty         = (cnt_q == '0);

  assign front_word = cell_data[0];

  always_comb begin
    back_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      back_word = back_word | cell_back[i];
    end
  end

  always_comb begin
    op     = CELL_HOLD;
    cnt_d  = cnt_q;
    result = '0;
    status = ST_OK;
    unique case (cmd_raw)
      CMD_PUSH_FRONT: begin
        if (full) status = ST_FULL;
        else begin
          op    = CELL_SHIFT_R;
          cnt_d = cnt_q + 1'b1;
        end
      end
      CMD_PUSH_BACK: begin
        if (full) status = ST_FULL;
        else begin
          op    = CELL_LOAD_BACK;
          cnt_d = cnt_q + 1'b1;
        end
      end
      CMD_POP_FRONT: begin
        if (empty) status = ST_EMPTY;
        else begin
          result = front_word;
          op     = CELL_SHIFT_L;
          cnt_d  = cnt_q - 1'b1;
        end
      end
      CMD_POP_BACK: begin
        if (empty) status = ST_EMPTY;
        else begin
          result = back_word;
          cnt_d  = cnt_q - 1'b1;
        end
      end
      CMD_PEEK_FRONT: begin
        if (empty) status = ST_EMPTY;
        else result = front_word;
      end
      CMD_PEEK_BACK: begin
        if (empty) status = ST_EMPTY;
        else result = back_word;
      end
      default: ;  // unused codes: no change
    endcase
  end

  assign cell_ctrl.op    = accept ? op : CELL_HOLD;
  assign cell_ctrl.wdata = value_in;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DATA_W-1:0] left_w, right_w;
    if (g == 0) begin : g_first
      assign left_w = value_in;
    end else begin : g_mid_l
      assign left_w = cell_data[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_data[g+1];
    end

    bdq_cell #(
      .CNT_W (CNT_W),
      .INDEX (g)
    ) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (cell_ctrl),
      .count_i     (cnt_q),
      .left_i      (left_w),
      .right_i     (right_w),
      .data_o      (cell_data[g]),
      .back_data_o (cell_back[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) cnt_q <= cnt_d;
      if (accept) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_value_q  <= result;
      out_status_q <= status;
      out_count_q  <= COUNT_W'(cnt_d);
      out_empty_q  <= (cnt_d == '0);
      out_full_q   <= (cnt_d == CNT_W'(DEPTH));
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'b0, out_full_q, out_empty_q, out_count_q,
                          out_status_q, out_value_q};

endmodule

`default_nettype wire

// ----- hw/rtl/bdq_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module bdq_checker
  import bdq_pkg::*;
(
  input wire                         clk_i,
  input wire                         rst_ni,
  input wire                         s_axis_tvalid,
  input wire                         s_axis_tready,
  input wire                         m_axis_tvalid,
  input wire                         m_axis_tready,
  input wire logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  logic [DATA_W-1:0]   o_value;
  logic [STATUS_W-1:0] o_status;
  logic [COUNT_W-1:0]  o_count;
  logic                o_empty, o_full;

  assign o_value  = m_axis_tdata[DATA_W-1:0];
  assign o_status = m_axis_tdata[DATA_W +: STATUS_W];
  assign o_count  = m_axis_tdata[DATA_W + STATUS_W +: COUNT_W];
  assign o_empty  = m_axis_tdata[DATA_W + STATUS_W + COUNT_W];
  assign o_full   = m_axis_tdata[DATA_W + STATUS_W + COUNT_W + 1];

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
    else $error("accepted item gave no result");

  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(o_empty && o_full))
    else $error("empty and full both set");

  a_empty_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((o_count == '0) == o_empty))
    else $error("empty flag disagrees with count");

  a_refused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (o_status == ST_FULL || o_status == ST_EMPTY) |-> o_value == '0)
    else $error("refused command returned a word");

endmodule

bind bounded_deque bdq_checker u_bdq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
